// ===== design/tstt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tstt_pkg: shared types and constants for the tick sleep timer table
// Beat payloads, result codes, controller states and the command/status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package tstt_pkg;

    localparam int          SLOTS_DEFAULT = 16;
    localparam logic [15:0] SLICE_RESET   = 16'd100;
    localparam logic [29:0] NS_PER_SEC    = 30'd1000000000;
    // largest seconds value whose nanosecond count stays below 2^63
    localparam logic [39:0] SECS_MAX      = 40'd9223372036;
    localparam int          DIV_STEPS     = 64;
    localparam int          CNT_W         = 6;
    localparam int          MUL_W         = 17;

    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_SLEEP = 1'b1;

    typedef enum logic [1:0] {
        KIND_WOKEN  = 2'd0,
        KIND_TICK   = 2'd1,
        KIND_ACCEPT = 2'd2,
        KIND_REJECT = 2'd3
    } kind_t;

    typedef struct packed {
        logic        req_type;
        logic [3:0]  thread_slot;
        logic [39:0] duration_seconds;
        logic [29:0] duration_nanos;
    } req_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] woken_slot;
        logic       yield_now;
        logic       last;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_TICK_DONE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ADD_NS,
        ST_DIV_INIT,
        ST_DIV,
        ST_ROUND,
        ST_SLEEP_DONE,
        ST_REJECT
    } state_t;

    typedef struct packed {
        logic  capture;
        logic  mul_lo;
        logic  mul_hi;
        logic  add_ns;
        logic  div_init;
        logic  div_step;
        logic  wake_write;
        logic  clear_valid;
        logic  out_load;
        kind_t out_kind;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_sleep;
        logic early_reject;
        logic ns_overflow;
        logic hit;
        logic out_free;
    } dp_status_t;

endpackage

// ===== design/tick_sleep_timer_table.sv =====
`timescale 1ns / 1ps
// Takes one request beat at a time. A tick beat is paced by the
// one-slot-at-a-time scan of the wake time memory over its single
// registered read port. A sleep beat is paced by the 64-step bit-serial
// ceiling divide of the nanosecond count by the time slice; a rejected
// sleep beat skips the divide. A result beat (woken sleeper, tick done,
// accept or reject) waits while the result register is stalled, and so
// holds up its request.
// Results leave through a one-beat register, so the next request is taken
// while the final result of the previous one still waits.
// ----------------------------------------------------------------------------
// tick_sleep_timer_table: tick timer with a sleeper table
// Counts ticks and time slices, turns sleep requests into wake ticks and
// reports woken sleepers in slot order on each tick.
// ----------------------------------------------------------------------------
module tick_sleep_timer_table #(
    parameter int SLOTS = tstt_pkg::SLOTS_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_wen,
    input  logic [15:0]     cfg_wdata,
    input  logic            req_valid,
    output logic            req_stall,
    input  tstt_pkg::req_t  req_data,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output tstt_pkg::rsp_t  rsp_data
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    tstt_pkg::ctrl_cmd_t  cmd;
    tstt_pkg::dp_status_t status;
    logic [IDX_W-1:0]     slot_idx;

    // sequence each request
    tstt_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd),
        .slot_idx  (slot_idx)
    );

    // hold counters, sleeper table and result register
    tstt_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .req_data  (req_data),
        .cmd       (cmd),
        .slot_idx  (slot_idx),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule

// ===== design/tstt_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tstt_dp: datapath of the tick sleep timer table
// Tick and slice counters, time slice register, request latch, duration
// multiply, bit-serial ceiling divide, wake time memory, valid bits and the
// result register.
// ----------------------------------------------------------------------------
module tstt_dp #(
    parameter int SLOTS = tstt_pkg::SLOTS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wen,
    input  logic [15:0]                        cfg_wdata,
    input  tstt_pkg::req_t                     req_data,
    input  tstt_pkg::ctrl_cmd_t                cmd,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] slot_idx,
    output tstt_pkg::dp_status_t               status,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output tstt_pkg::rsp_t                     rsp_data
);

    localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SCMP_W  = 7;

    // state
    logic [63:0]          tick_reg;
    logic [16:0]          slice_reg;
    logic                 yield_reg;
    logic [15:0]          time_slice_reg;
    tstt_pkg::req_t       req_reg;
    logic [63:0]          acc_reg;
    logic [15:0]          rem_reg;
    logic [SLOTS-1:0]     valid_reg;
    logic [63:0]          wake_mem [SLOTS];
    logic [63:0]          rd_reg;
    logic                 out_valid_reg;
    tstt_pkg::rsp_t       out_reg;

    // next values and helpers
    logic [63:0]          tick_next;
    logic [16:0]          slice_inc;
    logic [16:0]          slice_next;
    logic                 yield_next;
    logic [15:0]          divisor;
    logic [16:0]          div_ext;
    logic [16:0]          part_rem;
    logic                 part_ge;
    logic [15:0]          rem_next;
    logic [tstt_pkg::MUL_W-1:0] mul_a;
    logic [46:0]          product;
    logic [63:0]          acc_next;
    logic [64:0]          wake_sum;
    logic [63:0]          wake_next;
    logic [IDX_W-1:0]     wr_idx;
    tstt_pkg::rsp_t       out_next;

    // advance tick and slice counts, flag yield when the slice runs out
    always_comb
    begin
        tick_next  = tick_reg + 64'd1;
        slice_inc  = slice_reg + 17'd1;
        yield_next = (slice_inc > {1'b0, time_slice_reg});
        slice_next = yield_next ? 17'd0 : slice_inc;
    end

    // pick one half of the seconds for the shared multiplier
    always_comb
    begin
        mul_a   = cmd.mul_hi ? req_reg.duration_seconds[33:17]
                             : req_reg.duration_seconds[16:0];
        product = {30'd0, mul_a} * {17'd0, tstt_pkg::NS_PER_SEC};
    end

    // one restoring divide step: shift in the next dividend bit
    always_comb
    begin
        divisor  = (time_slice_reg == 16'd0) ? 16'd1 : time_slice_reg;
        div_ext  = {1'b0, divisor};
        part_rem = {rem_reg, acc_reg[63]};
        part_ge  = (part_rem >= div_ext);
        rem_next = part_ge ? 16'(part_rem - div_ext) : part_rem[15:0];
    end

    // accumulator: product halves, nanos, then quotient bits
    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.mul_lo)
        begin
            acc_next = 64'(product);
        end
        else if (cmd.mul_hi)
        begin
            acc_next = acc_reg + (64'(product) << 17);
        end
        else if (cmd.add_ns)
        begin
            acc_next = acc_reg + 64'(req_reg.duration_nanos);
        end
        else if (cmd.div_step)
        begin
            acc_next = {acc_reg[62:0], part_ge};
        end
    end

    // round the quotient up and add it to the tick count, saturating
    always_comb
    begin
        wake_sum  = {1'b0, tick_reg} + {1'b0, acc_reg} + 65'(rem_reg != 16'd0);
        wake_next = wake_sum[64] ? {64{1'b1}} : wake_sum[63:0];
        wr_idx    = IDX_W'(req_reg.thread_slot);
    end

    // build the result beat
    always_comb
    begin
        out_next.kind       = cmd.out_kind;
        out_next.woken_slot = (cmd.out_kind == tstt_pkg::KIND_WOKEN) ? 4'(slot_idx) : 4'd0;
        out_next.yield_now  = (cmd.out_kind == tstt_pkg::KIND_TICK) ? yield_reg : 1'b0;
        out_next.last       = (cmd.out_kind != tstt_pkg::KIND_WOKEN);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg       <= 64'd0;
            slice_reg      <= 17'd0;
            yield_reg      <= 1'b0;
            time_slice_reg <= tstt_pkg::SLICE_RESET;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                time_slice_reg <= cfg_wdata;
            end
            if (cmd.capture && (req_data.req_type == tstt_pkg::REQ_TICK))
            begin
                tick_reg  <= tick_next;
                slice_reg <= slice_next;
                yield_reg <= yield_next;
            end
            if (cmd.wake_write)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            else if (cmd.clear_valid)
            begin
                valid_reg[slot_idx] <= 1'b0;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req_data;
        end
        acc_reg <= acc_next;
        if (cmd.div_init)
        begin
            rem_reg <= 16'd0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
        end
        if (cmd.out_load)
        begin
            out_reg <= out_next;
        end
    end

    // wake time memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wake_write)
        begin
            wake_mem[wr_idx] <= wake_next;
        end
        rd_reg <= wake_mem[slot_idx];
    end

    // status back to the controller
    always_comb
    begin
        status.is_sleep     = (req_data.req_type == tstt_pkg::REQ_SLEEP);
        status.early_reject = (SCMP_W'(req_reg.thread_slot) >= SCMP_W'(SLOTS))
                           || (req_reg.duration_seconds > tstt_pkg::SECS_MAX);
        status.ns_overflow  = acc_reg[63];
        status.hit          = valid_reg[slot_idx] && (rd_reg <= tick_reg);
        status.out_free     = !out_valid_reg || !rsp_stall;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

endmodule

// ===== design/tstt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tstt_ctrl: controller of the tick sleep timer table
// Sequences the slot scan of a tick and the multiply, divide and wake time
// update of a sleep request, and issues result beats.
// ----------------------------------------------------------------------------
module tstt_ctrl #(
    parameter int SLOTS = tstt_pkg::SLOTS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  tstt_pkg::dp_status_t               status,
    output tstt_pkg::ctrl_cmd_t                cmd,
    output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] slot_idx
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    tstt_pkg::state_t              state_reg;
    tstt_pkg::state_t              state_next;
    logic [IDX_W-1:0]              idx_reg;
    logic [IDX_W-1:0]              idx_next;
    logic [tstt_pkg::CNT_W-1:0]    cnt_reg;
    logic [tstt_pkg::CNT_W-1:0]    cnt_next;
    logic                          accept;
    logic                          last_slot;
    logic                          last_step;

    assign accept    = req_valid && (state_reg == tstt_pkg::ST_IDLE);
    assign last_slot = (idx_reg == IDX_W'(SLOTS - 1));
    assign last_step = (cnt_reg == tstt_pkg::CNT_W'(tstt_pkg::DIV_STEPS - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tstt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = status.is_sleep ? tstt_pkg::ST_MUL_LO : tstt_pkg::ST_SCAN_RD;
                end
            end
            tstt_pkg::ST_SCAN_RD:
            begin
                state_next = tstt_pkg::ST_SCAN_CMP;
            end
            tstt_pkg::ST_SCAN_CMP:
            begin
                if (!status.hit || status.out_free)
                begin
                    state_next = last_slot ? tstt_pkg::ST_TICK_DONE : tstt_pkg::ST_SCAN_RD;
                end
            end
            tstt_pkg::ST_TICK_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = tstt_pkg::ST_IDLE;
                end
            end
            tstt_pkg::ST_MUL_LO:
            begin
                state_next = status.early_reject ? tstt_pkg::ST_REJECT : tstt_pkg::ST_MUL_HI;
            end
            tstt_pkg::ST_MUL_HI:
            begin
                state_next = tstt_pkg::ST_ADD_NS;
            end
            tstt_pkg::ST_ADD_NS:
            begin
                state_next = tstt_pkg::ST_DIV_INIT;
            end
            tstt_pkg::ST_DIV_INIT:
            begin
                state_next = status.ns_overflow ? tstt_pkg::ST_REJECT : tstt_pkg::ST_DIV;
            end
            tstt_pkg::ST_DIV:
            begin
                if (last_step)
                begin
                    state_next = tstt_pkg::ST_ROUND;
                end
            end
            tstt_pkg::ST_ROUND:
            begin
                state_next = tstt_pkg::ST_SLEEP_DONE;
            end
            tstt_pkg::ST_SLEEP_DONE, tstt_pkg::ST_REJECT:
            begin
                if (status.out_free)
                begin
                    state_next = tstt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tstt_pkg::ST_IDLE;
            end
        endcase
    end

    // scan index and divide step count
    always_comb
    begin
        idx_next = idx_reg;
        cnt_next = cnt_reg;
        case (state_reg)
            tstt_pkg::ST_IDLE:
            begin
                idx_next = '0;
            end
            tstt_pkg::ST_SCAN_CMP:
            begin
                if ((!status.hit || status.out_free) && !last_slot)
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            tstt_pkg::ST_DIV_INIT:
            begin
                cnt_next = '0;
            end
            tstt_pkg::ST_DIV:
            begin
                cnt_next = cnt_reg + tstt_pkg::CNT_W'(1);
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    // commands to the datapath
    always_comb
    begin
        cmd          = '0;
        cmd.out_kind = tstt_pkg::KIND_WOKEN;
        cmd.capture  = accept;
        case (state_reg)
            tstt_pkg::ST_SCAN_CMP:
            begin
                if (status.hit && status.out_free)
                begin
                    cmd.out_load    = 1'b1;
                    cmd.clear_valid = 1'b1;
                end
            end
            tstt_pkg::ST_TICK_DONE:
            begin
                cmd.out_kind = tstt_pkg::KIND_TICK;
                cmd.out_load = status.out_free;
            end
            tstt_pkg::ST_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
            end
            tstt_pkg::ST_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
            end
            tstt_pkg::ST_ADD_NS:
            begin
                cmd.add_ns = 1'b1;
            end
            tstt_pkg::ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
            end
            tstt_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            tstt_pkg::ST_ROUND:
            begin
                cmd.wake_write = 1'b1;
            end
            tstt_pkg::ST_SLEEP_DONE:
            begin
                cmd.out_kind = tstt_pkg::KIND_ACCEPT;
                cmd.out_load = status.out_free;
            end
            tstt_pkg::ST_REJECT:
            begin
                cmd.out_kind = tstt_pkg::KIND_REJECT;
                cmd.out_load = status.out_free;
            end
            default:
            begin
                cmd.out_load = 1'b0;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tstt_pkg::ST_IDLE;
            idx_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign req_stall = (state_reg != tstt_pkg::ST_IDLE);
    assign slot_idx  = idx_reg;

endmodule
